@@ rtl/ptg_pkg.sv @@
package ptg_pkg;

  // Fixed-point constants of the phase and cosine path.
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

  // Series divisors of the cosine, in evaluation order.
  localparam int unsigned COS_TERMS = 5;
  localparam int unsigned COS_DIVS [COS_TERMS] = '{90, 56, 30, 12, 2};

  // Cycles from the lane operand register to the lane key.
  localparam int unsigned LANE_LAT = 42;

  // Number of parallel distance lanes, one per cell corner.
  localparam int unsigned NUM_LANES = 4;

  typedef enum logic [1:0] {
    REG_CORNER = 2'd0,
    REG_LON_IN = 2'd1,
    REG_COL_IN = 2'd2,
    REG_BOTH   = 2'd3
  } region_e;

  // Operands of one distance evaluation.
  typedef struct packed {
    logic signed [31:0] ce;
    logic signed [31:0] le;
    logic        [31:0] re;
    logic signed [31:0] cs;
    logic signed [31:0] ls;
    logic        [31:0] rs;
  } lane_in_t;

endpackage

@@ rtl/ptg_cos_step.sv @@
module ptg_cos_step #(
  parameter int unsigned DIV = 90
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] t_i,
  output logic        valid_o,
  output logic [31:0] x2_o,
  output logic [30:0] t_o
);
  import ptg_pkg::*;

  localparam int unsigned RecipShift = 36;
  localparam logic [36:0] Recip = 37'((64'd1 << RecipShift) / DIV);
  localparam logic [32:0] DivC  = 33'(DIV);

  logic        v1_q, v2_q, v3_q;
  logic [31:0] x2a_q, x2b_q, x2c_q;
  logic [32:0] va_q, vb_q;
  logic [32:0] q0_q;
  logic [30:0] t_q;
  logic [62:0] prod;
  logic [69:0] rprod;
  logic [32:0] rem, q;

  // Valid bits follow the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Product of the running term with the squared angle.
  assign prod = x2_i * t_i;
  // Quotient estimate by reciprocal multiplication.
  assign rprod = va_q * Recip;
  // The estimate is at most one low; one correction step fixes it.
  assign rem = vb_q - q0_q * DivC;
  assign q   = (rem >= DivC) ? q0_q + 33'd1 : q0_q;

  always_ff @(posedge clk_i) begin
    va_q  <= prod[62:30];
    x2a_q <= x2_i;
    q0_q  <= rprod[RecipShift+32:RecipShift];
    vb_q  <= va_q;
    x2b_q <= x2a_q;
    t_q   <= (q >= {2'b0, Q30_ONE}) ? 31'd0 : Q30_ONE - q[30:0];
    x2c_q <= x2b_q;
  end

  assign valid_o = v3_q;
  assign x2_o    = x2c_q;
  assign t_o     = t_q;

endmodule

@@ rtl/ptg_isqrt.sv @@
module ptg_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] n_i,
  input  logic        sat_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output logic        sat_o
);
  import ptg_pkg::*;

  localparam int unsigned Stages = 16;

  logic        vld_q  [Stages];
  logic        sat_q  [Stages];
  logic [63:0] n_q    [Stages];
  logic [33:0] rem_q  [Stages];
  logic [31:0] root_q [Stages];

  // One restoring square-root iteration on the next pair of radicand bits.
  function automatic logic [65:0] sqrt_iter(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
    logic [35:0] rem_s;
    logic [35:0] trial;
    logic [33:0] rem_n;
    logic [31:0] root_n;
    rem_s = {rem, pair};
    trial = {2'b0, root, 2'b01};
    if (rem_s >= trial) begin
      rem_n  = 34'(rem_s - trial);
      root_n = {root[30:0], 1'b1};
    end else begin
      rem_n  = rem_s[33:0];
      root_n = {root[30:0], 1'b0};
    end
    return {rem_n, root_n};
  endfunction

  // Each stage retires two result bits.
  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic        vin, sin;
    logic [63:0] nin;
    logic [33:0] rin;
    logic [31:0] oin;
    logic [65:0] s1, s2;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign sin = sat_i;
      assign nin = n_i;
      assign rin = '0;
      assign oin = '0;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign sin = sat_q[k-1];
      assign nin = n_q[k-1];
      assign rin = rem_q[k-1];
      assign oin = root_q[k-1];
    end

    assign s1 = sqrt_iter(rin, oin, nin[63:62]);
    assign s2 = sqrt_iter(s1[65:32], s1[31:0], nin[61:60]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[k]  <= sin;
      n_q[k]    <= {nin[59:0], 4'd0};
      rem_q[k]  <= s2[65:32];
      root_q[k] <= s2[31:0];
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign root_o  = root_q[Stages-1];
  assign sat_o   = sat_q[Stages-1];

endmodule

@@ rtl/ptg_span.sv @@
module ptg_span #(
  parameter int unsigned ANGLE_FRAC_BITS = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ptg_pkg::lane_in_t op_i,
  output logic              valid_o,
  output logic [32:0]       key_o
);
  import ptg_pkg::*;

  localparam int unsigned ArcShift  = 2 * ANGLE_FRAC_BITS - 1;
  localparam int unsigned SideDepth = 20;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] dr;
    logic [31:0] re;
    logic [31:0] rs;
  } side_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, vp1_q, vp2_q, vp3_q;

  logic signed [32:0] csum, cadj, dc, dl;
  side_t              side_d;
  side_t              side_q [SideDepth];
  logic signed [31:0] m_q;
  logic signed [62:0] p_q;
  logic        [31:0] u;
  logic        [30:0] r_q;
  logic        [61:0] xp;
  logic        [31:0] x_q;
  logic        [63:0] x2p;
  logic        [31:0] x2_q;

  logic              cv   [COS_TERMS+1];
  logic       [31:0] cx2  [COS_TERMS+1];
  logic       [30:0] ct   [COS_TERMS+1];

  logic [62:0]  bcp;
  logic [31:0]  bc_q;
  logic [63:0]  a2_q, a2b_q, bc2_q;
  logic [63:0]  dr2_q, dr2b_q, dr2c_q, dr2d_q, dr2e_q;
  logic [63:0]  rr_q, rrb_q, rrc_q;
  logic [63:0]  dang_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] full_q;
  logic [127:0] arc_w;
  logic         ovf;
  logic [64:0]  sum;
  logic [63:0]  n_q;
  logic         sat_q;
  logic         sq_v, sq_sat;
  logic [31:0]  sq_root;

  // Valid bits of the stages ahead of and behind the cosine chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= cv[COS_TERMS];
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      vp1_q <= v8_q;
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
    end
  end

  // Mean colatitude, truncated toward zero, and the absolute differences.
  always_comb begin
    csum      = {op_i.ce[31], op_i.ce} + {op_i.cs[31], op_i.cs};
    cadj      = csum + {32'd0, csum[32]};
    dc        = {op_i.ce[31], op_i.ce} - {op_i.cs[31], op_i.cs};
    dl        = {op_i.le[31], op_i.le} - {op_i.ls[31], op_i.ls};
    side_d.a  = dc[32] ? 32'(-dc) : dc[31:0];
    side_d.b  = dl[32] ? 32'(-dl) : dl[31:0];
    side_d.dr = (op_i.re > op_i.rs) ? op_i.re - op_i.rs : op_i.rs - op_i.re;
    side_d.re = op_i.re;
    side_d.rs = op_i.rs;
  end

  // Phase in turns, folded into the first quadrant.
  assign u   = p_q[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
  assign xp  = r_q * HALF_PI_Q30;
  assign x2p = x_q * x_q;

  always_ff @(posedge clk_i) begin
    m_q       <= cadj[32:1];
    side_q[0] <= side_d;
    p_q       <= m_q * $signed({1'b0, INV_TWO_PI_Q32});
    r_q       <= u[30] ? Q30_ONE - {1'b0, u[29:0]} : {1'b0, u[29:0]};
    x_q       <= xp[61:30];
    x2_q      <= x2p[61:30];
  end

  // Operand side data waits for the cosine.
  for (genvar k = 1; k < SideDepth; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Cosine series, one term per step.
  assign cv[0]  = v5_q;
  assign cx2[0] = x2_q;
  assign ct[0]  = Q30_ONE;

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    ptg_cos_step #(
      .DIV(COS_DIVS[i])
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[i]),
      .x2_i   (cx2[i]),
      .t_i    (ct[i]),
      .valid_o(cv[i+1]),
      .x2_o   (cx2[i+1]),
      .t_o    (ct[i+1])
    );
  end

  // Squares and the radius product.
  assign bcp = side_q[SideDepth-1].b * ct[COS_TERMS];

  always_ff @(posedge clk_i) begin
    bc_q   <= bcp[61:30];
    a2_q   <= side_q[SideDepth-1].a * side_q[SideDepth-1].a;
    dr2_q  <= side_q[SideDepth-1].dr * side_q[SideDepth-1].dr;
    rr_q   <= side_q[SideDepth-1].re * side_q[SideDepth-1].rs;
    bc2_q  <= bc_q * bc_q;
    a2b_q  <= a2_q;
    dr2b_q <= dr2_q;
    rrb_q  <= rr_q;
    dang_q <= {1'b0, a2b_q[63:1]} + {1'b0, bc2_q[63:1]};
    dr2c_q <= dr2b_q;
    rrc_q  <= rrb_q;
  end

  // Wide product of the angular term and the radius product in four pieces.
  always_ff @(posedge clk_i) begin
    ll_q   <= dang_q[31:0] * rrc_q[31:0];
    lh_q   <= dang_q[31:0] * rrc_q[63:32];
    hl_q   <= dang_q[63:32] * rrc_q[31:0];
    hh_q   <= dang_q[63:32] * rrc_q[63:32];
    dr2d_q <= dr2c_q;
    full_q <= {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {hh_q, 64'd0};
    dr2e_q <= dr2d_q;
  end

  // Scale the arc term and add the radial term, flagging overflow.
  assign arc_w = full_q >> ArcShift;
  assign ovf   = |arc_w[127:64];
  assign sum   = {1'b0, dr2e_q} + {1'b0, arc_w[63:0]};

  always_ff @(posedge clk_i) begin
    n_q   <= sum[63:0];
    sat_q <= ovf | sum[64];
  end

  ptg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vp3_q),
    .n_i    (n_q),
    .sat_i  (sat_q),
    .valid_o(sq_v),
    .root_o (sq_root),
    .sat_o  (sq_sat)
  );

  assign valid_o = sq_v;
  assign key_o   = sq_sat ? 33'h1_0000_0000 : {1'b0, sq_root};

endmodule

@@ rtl/point_to_grid_cell_min_distance_top.sv @@
// Channel   Direction  Ports                                      Handshake
// command   in         obs_*_i, cell_*_i, face_radius_i           start_i while busy_o low
// result    out        min_distance_o, region_o, saturated_o      done_o strobe, one cycle
//
// A transaction may be issued in every cycle; busy_o stays low.
// Each result strobe follows its command through the input register, the operand register,
// the four parallel distance lanes (phase and cosine series, wide product, 16-stage
// square root) and the result register.
// Reset clears only the valid bits; no result is pending after reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module point_to_grid_cell_min_distance_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] obs_colat_i,
  input  logic [31:0] obs_lon_i,
  input  logic [31:0] obs_radius_i,
  input  logic [31:0] cell_colat_min_i,
  input  logic [31:0] cell_lon_min_i,
  input  logic [31:0] cell_colat_max_i,
  input  logic [31:0] cell_lon_max_i,
  input  logic [31:0] face_radius_i,
  output logic        done_o,
  output logic [31:0] min_distance_o,
  output logic [1:0]  region_o,
  output logic        saturated_o
);
  import ptg_pkg::*;

  typedef struct packed {
    region_e     region;
    logic [31:0] dr;
  } tag_t;

  logic               va_q, vb_q, out_v_q;
  logic signed [31:0] ce_q, le_q, c1_q, l1_q, c2_q, l2_q;
  logic        [31:0] re_q, rs_q;

  logic        lon_in, col_in;
  region_e     region;
  logic [32:0] dc1, dc2, dl1, dl2;
  logic [31:0] mc1, mc2, ml1, ml2;
  logic signed [31:0] cedge, ledge;
  lane_in_t    op_d [NUM_LANES];
  lane_in_t    op_q [NUM_LANES];
  tag_t        tag_d;
  tag_t        tag_q [LANE_LAT+1];

  logic        lane_v [NUM_LANES];
  logic [32:0] lane_k [NUM_LANES];
  logic [32:0] min01, min23, kmin, key;

  logic [31:0] dist_q;
  region_e     region_q;
  logic        sat_q;

  assign busy_o = 1'b0;

  // Valid bits of the input, classification and result stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      va_q    <= start_i;
      vb_q    <= va_q;
      out_v_q <= lane_v[0];
    end
  end

  // Capture the command transaction.
  always_ff @(posedge clk_i) begin
    ce_q <= obs_colat_i;
    le_q <= obs_lon_i;
    re_q <= obs_radius_i;
    c1_q <= cell_colat_min_i;
    l1_q <= cell_lon_min_i;
    c2_q <= cell_colat_max_i;
    l2_q <= cell_lon_max_i;
    rs_q <= face_radius_i;
  end

  // Region, nearer edges and lane operands.
  always_comb begin
    lon_in = (le_q >= l1_q) && (le_q <= l2_q);
    col_in = (ce_q >= c1_q) && (ce_q <= c2_q);
    region = region_e'({col_in, lon_in});
    dc1    = {ce_q[31], ce_q} - {c1_q[31], c1_q};
    dc2    = {ce_q[31], ce_q} - {c2_q[31], c2_q};
    dl1    = {le_q[31], le_q} - {l1_q[31], l1_q};
    dl2    = {le_q[31], le_q} - {l2_q[31], l2_q};
    mc1    = dc1[32] ? 32'(-dc1) : dc1[31:0];
    mc2    = dc2[32] ? 32'(-dc2) : dc2[31:0];
    ml1    = dl1[32] ? 32'(-dl1) : dl1[31:0];
    ml2    = dl2[32] ? 32'(-dl2) : dl2[31:0];
    // On a tie the upper bound is taken.
    cedge  = (mc1 < mc2) ? c1_q : c2_q;
    ledge  = (ml1 < ml2) ? l1_q : l2_q;

    for (int i = 0; i < NUM_LANES; i++) begin
      op_d[i].ce = ce_q;
      op_d[i].le = le_q;
      op_d[i].re = re_q;
      op_d[i].rs = rs_q;
      op_d[i].cs = (i < 2) ? c1_q : c2_q;
      op_d[i].ls = (i % 2 == 0) ? l1_q : l2_q;
    end

    case (region)
      REG_LON_IN: begin
        op_d[0].cs = cedge;
        op_d[0].ls = le_q;
      end
      REG_COL_IN: begin
        op_d[0].cs = ce_q;
        op_d[0].ls = ledge;
      end
      default: begin
      end
    endcase

    tag_d.region = region;
    tag_d.dr     = (re_q > rs_q) ? re_q - rs_q : rs_q - re_q;
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tag_q[0] <= tag_d;
  end

  // Region and radius difference travel alongside the lanes.
  for (genvar k = 1; k <= LANE_LAT; k++) begin : g_tag
    always_ff @(posedge clk_i) begin
      tag_q[k] <= tag_q[k-1];
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    ptg_span #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_span (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vb_q),
      .op_i   (op_q[i]),
      .valid_o(lane_v[i]),
      .key_o  (lane_k[i])
    );
  end

  // Least corner key, lane 0 key on an edge, |dr| inside; saturated keys rank above all.
  always_comb begin
    min01 = (lane_k[1] < lane_k[0]) ? lane_k[1] : lane_k[0];
    min23 = (lane_k[3] < lane_k[2]) ? lane_k[3] : lane_k[2];
    kmin  = (min23 < min01) ? min23 : min01;
    case (tag_q[LANE_LAT].region)
      REG_CORNER: key = kmin;
      REG_BOTH:   key = {1'b0, tag_q[LANE_LAT].dr};
      default:    key = lane_k[0];
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    dist_q   <= key[32] ? 32'hFFFF_FFFF : key[31:0];
    sat_q    <= key[32];
    region_q <= tag_q[LANE_LAT].region;
  end

  assign done_o         = out_v_q;
  assign min_distance_o = dist_q;
  assign region_o       = region_q;
  assign saturated_o    = sat_q;

endmodule
